>>> src/cvlfo_pkg.sv
// Shared types, constants and lookup tables for the CV LFO generator.
// Depends on nothing; every other file imports it.
package cvlfo_pkg;

   // Sine table geometry: floor(log2(SINE_POINTS)) index bits
   localparam int SINE_POINTS = 256;
   localparam int SINE_BITS   = $clog2(SINE_POINTS + 1) - 1;
   localparam int SINE_SIZE   = 1 << SINE_BITS;
   localparam int FRAC_MSB    = 31 - SINE_BITS;

   // Configuration port geometry
   localparam int ADDR_W = 4;
   localparam int DATA_W = 32;

   // Register indexes (byte address / 4)
   localparam logic [1:0] REG_WAVE_MODE    = 2'd0;
   localparam logic [1:0] REG_OUTPUT_RANGE = 2'd1;
   localparam logic [1:0] REG_MIDI_SOURCE  = 2'd2;
   localparam logic [1:0] REG_PHASE_STEP   = 2'd3;

   // Register reset values
   localparam logic [3:0]  WAVE_MODE_RST    = 4'd0;
   localparam logic [2:0]  OUTPUT_RANGE_RST = 3'd2;
   localparam logic [2:0]  MIDI_SOURCE_RST  = 3'd0;
   localparam logic [31:0] PHASE_STEP_RST   = 32'd0;

   // Wave mode codes
   localparam logic [3:0] WAVE_TRI       = 4'd0;
   localparam logic [3:0] WAVE_SQUARE    = 4'd1;
   localparam logic [3:0] WAVE_RAMP_UP   = 4'd2;
   localparam logic [3:0] WAVE_RAMP_DOWN = 4'd3;
   localparam logic [3:0] WAVE_SINE      = 4'd4;
   localparam logic [3:0] WAVE_OCT_ARP   = 4'd5;
   localparam logic [3:0] WAVE_2OCT_ARP  = 4'd6;
   localparam logic [3:0] WAVE_CHROMA    = 4'd7;
   localparam logic [3:0] WAVE_C1        = 4'd8;
   localparam logic [3:0] WAVE_C3        = 4'd9;

   // MIDI source codes
   localparam logic [2:0] MIDI_OFF      = 3'd0;
   localparam logic [2:0] MIDI_NOTE     = 3'd1;
   localparam logic [2:0] MIDI_VELOCITY = 3'd2;
   localparam logic [2:0] MIDI_BEND     = 3'd3;
   localparam logic [2:0] MIDI_WHEEL    = 3'd4;

   // Fixed pitch codes and note conversion constants
   localparam logic [15:0] CODE_C1       = 16'd1715;
   localparam logic [15:0] CODE_C2       = 16'd1381;
   localparam logic [15:0] CODE_C3       = 16'd1048;
   localparam logic [15:0] PITCH_CENTRE  = 16'd2048;
   localparam logic [15:0] SCALE_MIDDLE  = 16'd32767;
   localparam logic [7:0]  NOTE_BASE     = 8'd36;
   localparam logic [14:0] NOTE_SLOPE    = 15'd7111;
   localparam logic [11:0] CHROMA_STEPS  = 12'd13;

   // Output range tables, last entry also serves out-of-range selects
   localparam logic [2:0] RANGE_LAST = 3'd5;
   localparam logic [15:0] RANGE_SCALE [6] = '{
      16'd667, 16'd1333, 16'd3333, 16'd333, 16'd667, 16'd1667};
   localparam logic [15:0] RANGE_OFFSET [6] = '{
      16'd2048, 16'd2048, 16'd2048, 16'd1881, 16'd1715, 16'd1215};

   localparam logic [15:0] CHROMA_CODES [13] = '{
      16'd1715, 16'd1687, 16'd1659, 16'd1631, 16'd1604, 16'd1576,
      16'd1548, 16'd1520, 16'd1492, 16'd1465, 16'd1437, 16'd1409, 16'd1381};

   // Configuration seen by the datapath
   typedef struct packed {
      logic [3:0]  wave_mode;
      logic [2:0]  output_range;
      logic [2:0]  midi_source;
      logic [31:0] phase_step;
   } cfg_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHAPE,
      ST_INTERP,
      ST_MUL,
      ST_DONE
   } fsm_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;
      logic shape;
      logic interp;
      logic mul;
      logic done;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic out_free;
   } status_type;

   // Sine table, built at elaboration
   typedef logic [15:0] sine_tab_type [SINE_SIZE];

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   // Quarter-wave sine by Taylor series in Q30, scaled to 0..32767
   function automatic longint quarter_sine(longint unsigned j);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      x    = (HALF_PI_Q30 * j) >> (SINE_BITS - 2);
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + longint'(term);
      if (sum < 0) begin
         sum = 0;
      end
      sum = (sum * 32767 + (longint'(1) << 29)) >>> 30;
      if (sum > 32767) begin
         sum = 32767;
      end
      return sum;
   endfunction

   // Full period; the wrap entry equals entry zero and is not stored
   function automatic sine_tab_type build_sine();
      sine_tab_type    t;
      longint unsigned n;
      longint unsigned q;
      longint          s;
      n = longint'(SINE_SIZE);
      q = n >> 2;
      for (int i = 0; i < SINE_SIZE; i++) begin
         if (longint'(i) <= q) begin
            s = quarter_sine(longint'(i));
         end else if (longint'(i) <= 2 * q) begin
            s = quarter_sine(2 * q - longint'(i));
         end else if (longint'(i) <= 3 * q) begin
            s = -quarter_sine(longint'(i) - 2 * q);
         end else begin
            s = -quarter_sine(n - longint'(i));
         end
         t[i] = 16'(longint'(32768) + s);
      end
      return t;
   endfunction

   localparam sine_tab_type SINE_TAB = build_sine();

endpackage

>>> src/cv_lfo_generator_unit.sv
// CV LFO generator top level: configuration registers, sequencer, datapath.
// Each accepted item walks the shape, interpolate, multiply and result stages
// before rsp_valid; the result stage waits while the output register is full.
// No new item is accepted until the last is loaded into the output register.
// Reset: configuration to defaults, phase and held pitch cleared, no clear pass.
module cv_lfo_generator_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_note_held,
   input  logic [6:0]                    req_note_number,
   input  logic [6:0]                    req_note_velocity,
   input  logic [13:0]                   req_bend_amount,
   input  logic [6:0]                    req_wheel_amount,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [15:0]                   rsp_cv_code,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [cvlfo_pkg::ADDR_W-1:0]  paddr,
   input  logic [cvlfo_pkg::DATA_W-1:0]  pwdata,
   output logic [cvlfo_pkg::DATA_W-1:0]  prdata,
   output logic                          pready
);
   import cvlfo_pkg::*;

   logic [3:0]  wave_mode_ff;
   logic [2:0]  output_range_ff;
   logic [2:0]  midi_source_ff;
   logic [31:0] phase_step_ff;
   logic        cfg_write;
   logic [1:0]  reg_idx;
   cfg_type     cfg;
   cmd_type     cmd;
   status_type  status;

   assign pready    = 1'b1;
   assign reg_idx   = paddr[3:2];
   assign cfg_write = psel && penable && pwrite && pready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wave_mode_ff    <= WAVE_MODE_RST;
         output_range_ff <= OUTPUT_RANGE_RST;
         midi_source_ff  <= MIDI_SOURCE_RST;
         phase_step_ff   <= PHASE_STEP_RST;
      end else if (cfg_write) begin
         case (reg_idx)
            REG_WAVE_MODE:    wave_mode_ff    <= pwdata[3:0];
            REG_OUTPUT_RANGE: output_range_ff <= pwdata[2:0];
            REG_MIDI_SOURCE:  midi_source_ff  <= pwdata[2:0];
            REG_PHASE_STEP:   phase_step_ff   <= pwdata;
            default: begin
            end
         endcase
      end
   end

   // Register read-back
   always_comb begin
      case (reg_idx)
         REG_WAVE_MODE:    prdata = {28'd0, wave_mode_ff};
         REG_OUTPUT_RANGE: prdata = {29'd0, output_range_ff};
         REG_MIDI_SOURCE:  prdata = {29'd0, midi_source_ff};
         REG_PHASE_STEP:   prdata = phase_step_ff;
         default:          prdata = '0;
      endcase
   end

   assign cfg.wave_mode    = wave_mode_ff;
   assign cfg.output_range = output_range_ff;
   assign cfg.midi_source  = midi_source_ff;
   assign cfg.phase_step   = phase_step_ff;

   cvlfo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   cvlfo_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .cmd               (cmd),
      .status            (status),
      .req_note_held     (req_note_held),
      .req_note_number   (req_note_number),
      .req_note_velocity (req_note_velocity),
      .req_bend_amount   (req_bend_amount),
      .req_wheel_amount  (req_wheel_amount),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_cv_code       (rsp_cv_code)
   );

   // One item in flight: no acceptance in the cycle after an acceptance
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("item accepted while another is in flight");

   // An item accepted with the output empty reaches rsp_valid without waiting in done
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !rsp_valid) |-> ##5 rsp_valid)
      else $error("result missing five cycles after acceptance");

endmodule

>>> src/cvlfo_ctrl.sv
// Sequencer for the CV LFO generator: steps one item through the datapath.
// Depends on cvlfo_pkg for the state, command and status types.
module cvlfo_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  cvlfo_pkg::status_type status,
   output cvlfo_pkg::cmd_type    cmd
);
   import cvlfo_pkg::*;

   fsm_state_type state_ff;
   fsm_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = ST_SHAPE;
            end
         end
         ST_SHAPE: begin
            cmd.shape = 1'b1;
            state_in  = ST_INTERP;
         end
         ST_INTERP: begin
            cmd.interp = 1'b1;
            state_in   = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register can take the item
            if (status.out_free) begin
               cmd.done = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> src/cvlfo_datapath.sv
// Datapath of the CV LFO generator: phase accumulator, wave shaping,
// sine interpolation, range scaling and the output register. Uses cvlfo_pkg.
module cvlfo_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  cvlfo_pkg::cfg_type    cfg,
   input  cvlfo_pkg::cmd_type    cmd,
   output cvlfo_pkg::status_type status,
   input  logic                  req_note_held,
   input  logic [6:0]            req_note_number,
   input  logic [6:0]            req_note_velocity,
   input  logic [13:0]           req_bend_amount,
   input  logic [6:0]            req_wheel_amount,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [15:0]           rsp_cv_code
);
   import cvlfo_pkg::*;

   // State and per-item registers
   logic [31:0]          phase_ff;
   logic [15:0]          held_pitch_ff;
   logic                 note_held_ff;
   logic [6:0]           note_number_ff;
   logic [6:0]           note_velocity_ff;
   logic [13:0]          bend_ff;
   logic [6:0]           wheel_ff;
   logic [15:0]          sine_a_ff;
   logic [15:0]          sine_b_ff;
   logic [7:0]           frac_ff;
   logic [15:0]          raw_ff;
   logic [15:0]          v_ff;
   logic signed [31:0]   prod_ff;
   logic                 rsp_valid_ff;
   logic [15:0]          rsp_cv_code_ff;

   // Mode decode
   logic                 lfo_mode;
   logic                 sine_mode;
   logic                 scaled_mode;
   logic [2:0]           range_idx;

   always_comb begin
      lfo_mode    = (cfg.midi_source == MIDI_OFF);
      sine_mode   = lfo_mode && (cfg.wave_mode == WAVE_SINE);
      scaled_mode = lfo_mode ? (cfg.wave_mode inside {[WAVE_TRI:WAVE_SINE]})
                             : (cfg.midi_source != MIDI_NOTE);
      range_idx   = (cfg.output_range > RANGE_LAST) ? RANGE_LAST : cfg.output_range;
   end

   // Wave shaping and MIDI raw value
   logic [15:0]          phase_hi;
   logic [SINE_BITS-1:0] sine_idx;
   logic [SINE_BITS-1:0] sine_idx_next;
   logic [11:0]          chroma_prod;
   logic [3:0]           chroma_idx;
   logic [15:0]          raw_in;

   always_comb begin
      phase_hi      = phase_ff[31:16];
      sine_idx      = phase_ff[31 -: SINE_BITS];
      sine_idx_next = sine_idx + SINE_BITS'(1);
      chroma_prod   = 12'(phase_ff[31:24]) * CHROMA_STEPS;
      chroma_idx    = chroma_prod[11:8];
      raw_in        = '0;
      if (lfo_mode) begin
         case (cfg.wave_mode)
            WAVE_TRI:       raw_in = phase_hi[15] ? ~{phase_hi[14:0], 1'b0}
                                                  : {phase_hi[14:0], 1'b0};
            WAVE_SQUARE:    raw_in = {16{phase_hi[15]}};
            WAVE_RAMP_UP:   raw_in = phase_hi;
            WAVE_RAMP_DOWN: raw_in = ~phase_hi;
            WAVE_OCT_ARP:   raw_in = phase_hi[15] ? CODE_C1 : CODE_C2;
            WAVE_2OCT_ARP:  raw_in = phase_hi[15] ? CODE_C1 : CODE_C3;
            WAVE_CHROMA:    raw_in = CHROMA_CODES[chroma_idx];
            WAVE_C1:        raw_in = CODE_C1;
            WAVE_C3:        raw_in = CODE_C3;
            default:        raw_in = phase_hi;
         endcase
      end else begin
         case (cfg.midi_source)
            MIDI_VELOCITY: raw_in = note_held_ff ? {note_velocity_ff, 9'd0} : 16'd0;
            MIDI_BEND:     raw_in = {bend_ff, 2'd0};
            MIDI_WHEEL:    raw_in = {wheel_ff, 9'd0};
            default:       raw_in = 16'd0;
         endcase
      end
   end

   // Sine interpolation between neighbouring entries
   logic [15:0]          sine_diff;
   logic signed [24:0]   interp_prod;
   logic [15:0]          v_in;

   always_comb begin
      sine_diff   = sine_b_ff - sine_a_ff;
      interp_prod = 25'($signed(sine_diff)) * 25'($signed({1'b0, frac_ff}));
      v_in        = sine_mode ? (sine_a_ff + interp_prod[23:8]) : raw_ff;
   end

   // Shared multiplier: range scale or note pitch slope
   logic [7:0]           note_rel;
   logic [15:0]          scale_diff;
   logic signed [16:0]   mul_a;
   logic signed [14:0]   mul_b;
   logic signed [31:0]   prod_in;

   always_comb begin
      note_rel   = {1'b0, note_number_ff} - NOTE_BASE;
      scale_diff = SCALE_MIDDLE - v_ff;
      if (cfg.midi_source == MIDI_NOTE) begin
         mul_a = $signed({note_rel[7], note_rel, 8'd0});
         mul_b = $signed(NOTE_SLOPE);
      end else begin
         mul_a = $signed({scale_diff[15], scale_diff});
         mul_b = $signed(RANGE_SCALE[range_idx][14:0]);
      end
      prod_in = 32'(mul_a) * 32'(mul_b);
   end

   // Final result selection
   logic [15:0]          prod_hi;
   logic [15:0]          note_code;
   logic [15:0]          result;

   always_comb begin
      prod_hi   = prod_ff[31:16];
      note_code = PITCH_CENTRE - prod_hi;
      if (cfg.midi_source == MIDI_NOTE) begin
         result = note_held_ff ? note_code : held_pitch_ff;
      end else if (scaled_mode) begin
         result = prod_hi + RANGE_OFFSET[range_idx];
      end else begin
         result = v_ff;
      end
   end

   // Phase accumulator and remembered note pitch
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= '0;
         held_pitch_ff <= '0;
      end else begin
         if (cmd.accept && lfo_mode) begin
            phase_ff <= phase_ff + cfg.phase_step;
         end
         if (cmd.done && (cfg.midi_source == MIDI_NOTE) && note_held_ff) begin
            held_pitch_ff <= note_code;
         end
      end
   end

   // Item pipeline registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         note_held_ff     <= req_note_held;
         note_number_ff   <= req_note_number;
         note_velocity_ff <= req_note_velocity;
         bend_ff          <= req_bend_amount;
         wheel_ff         <= req_wheel_amount;
      end
      if (cmd.shape) begin
         sine_a_ff <= SINE_TAB[sine_idx];
         sine_b_ff <= SINE_TAB[sine_idx_next];
         frac_ff   <= phase_ff[FRAC_MSB -: 8];
         raw_ff    <= raw_in;
      end
      if (cmd.interp) begin
         v_ff <= v_in;
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.done) begin
         rsp_cv_code_ff <= result;
      end
   end

   // Output register: load on done, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.done) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cv_code     = rsp_cv_code_ff;

endmodule
